// ===== rtl/sfr_pkg.sv =====
// shared types, codes and reset values for the serial frame receiver
`default_nettype none

package sfr_pkg;

  // default size of the frame store, in bytes
  localparam int MaxFrameDef = 64;

  // configuration port geometry
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_GUARD = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SOF   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ACK   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_NACK  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CAN   = 3'd4;

  // register reset values
  localparam logic [15:0] GUARD_RST = 16'd1500;
  localparam logic [7:0]  SOF_RST   = 8'd1;
  localparam logic [7:0]  ACK_RST   = 8'd6;
  localparam logic [7:0]  NACK_RST  = 8'd21;
  localparam logic [7:0]  CAN_RST   = 8'd24;

  // checksum seed
  localparam logic [7:0] CHECK_SEED = 8'hFF;

  // request types
  localparam logic [1:0] REQ_BYTE    = 2'd0;
  localparam logic [1:0] REQ_TIMEOUT = 2'd1;

  // line replies
  localparam logic [1:0] REPLY_NONE = 2'd0;
  localparam logic [1:0] REPLY_ACK  = 2'd1;
  localparam logic [1:0] REPLY_NACK = 2'd2;

  // status codes
  localparam logic [3:0] ST_STORED     = 4'd0;
  localparam logic [3:0] ST_FRAME_OK   = 4'd1;
  localparam logic [3:0] ST_CONTROL    = 4'd2;
  localparam logic [3:0] ST_UNKNOWN    = 4'd3;
  localparam logic [3:0] ST_BAD_LEN    = 4'd4;
  localparam logic [3:0] ST_CHECKSUM   = 4'd5;
  localparam logic [3:0] ST_INCOMPLETE = 4'd6;
  localparam logic [3:0] ST_IGNORED    = 4'd7;
  localparam logic [3:0] ST_LINK_ERR   = 4'd8;

  // configuration register set
  typedef struct packed {
    logic [15:0] guard;
    logic [7:0]  sof;
    logic [7:0]  ack;
    logic [7:0]  nack;
    logic [7:0]  can;
  } cfg_t;

  // one result transaction
  typedef struct packed {
    logic       host_valid;
    logic [7:0] host_byte;
    logic       host_last;
    logic [1:0] line_reply;
    logic [3:0] status;
  } result_t;

  // parser outcome for one accepted input
  typedef struct packed {
    result_t res;
    logic    frame_ok;
  } parse_t;

endpackage

`default_nettype wire

// ===== rtl/serial_frame_receiver.sv =====
// serial frame receiver top level: registers, frame readout and output stage
//
//   channel  direction  handshake                 payload
//   input    in         in_valid_i / in_stall_o   req_type_i, data_byte_i, now_ms_i
//   output   out        out_valid_o / out_stall_i host_valid_o, host_byte_o, host_last_o,
//                                                 line_reply_o, status_o
//   config   in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
// an input with a single result is registered into the output register; inputs follow
// every cycle while the output register drains. a good frame streams from the frame store
// one byte a cycle, unless the output stalls, through its registered read port, with input
// stalled. reset clears control and config registers at once; the frame store needs no
// clearing pass. output stall holds the output register and stalls the input behind it.
`default_nettype none

module serial_frame_receiver import sfr_pkg::*; #(
  parameter int MAX_FRAME = MaxFrameDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [1:0]          req_type_i,
  input  wire logic [7:0]          data_byte_i,
  input  wire logic [31:0]         now_ms_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     host_valid_o,
  output logic      [7:0]          host_byte_o,
  output logic                     host_last_o,
  output logic      [1:0]          line_reply_o,
  output logic      [3:0]          status_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int AW = $clog2(MAX_FRAME);
  localparam int FW = $clog2(MAX_FRAME + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  cfg_t          cfg_q;
  parse_t        pres;
  logic [FW-1:0] plen;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [7:0]    rd_data;

  logic          state_q, state_d;
  logic [FW-1:0] len_q, len_d;
  logic [FW-1:0] rd_addr_q, rd_addr_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic          rd_pend_q, rd_pend_d;
  logic          out_valid_q, out_valid_d;
  result_t       out_q, out_d;

  logic          in_fire;
  logic          out_load;
  logic          move;
  logic          issue;
  logic          rd_last;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.guard <= GUARD_RST;
      cfg_q.sof   <= SOF_RST;
      cfg_q.ack   <= ACK_RST;
      cfg_q.nack  <= NACK_RST;
      cfg_q.can   <= CAN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GUARD: cfg_q.guard <= cfg_data_i;
        REG_SOF:   cfg_q.sof   <= cfg_data_i[7:0];
        REG_ACK:   cfg_q.ack   <= cfg_data_i[7:0];
        REG_NACK:  cfg_q.nack  <= cfg_data_i[7:0];
        REG_CAN:   cfg_q.can   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_load;
  assign in_fire    = in_valid_i && !in_stall_o;

  sfr_parser #(
    .MAX_FRAME (MAX_FRAME),
    .AW        (AW),
    .FW        (FW)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (in_fire),
    .req_type_i  (req_type_i),
    .data_byte_i (data_byte_i),
    .now_ms_i    (now_ms_i),
    .cfg_i       (cfg_q),
    .parse_o     (pres),
    .len_o       (plen),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  // readout pipeline control
  assign move    = (state_q == ST_READ) && rd_pend_q && out_load;
  assign issue   = (state_q == ST_READ) && (rd_addr_q != len_q) && (!rd_pend_q || move);
  assign rd_last = (FW'(rd_idx_q) + FW'(1)) == len_q;

  sfr_frame_store #(
    .DEPTH (MAX_FRAME),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (issue),
    .rd_addr_i (rd_addr_q[AW-1:0]),
    .rd_data_o (rd_data)
  );

  // sequencer and output register next state
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    rd_addr_d   = rd_addr_q;
    rd_idx_d    = rd_idx_q;
    rd_pend_d   = rd_pend_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_load) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (pres.frame_ok) begin
            state_d   = ST_READ;
            len_d     = plen;
            rd_addr_d = '0;
            rd_pend_d = 1'b0;
          end else begin
            out_valid_d = 1'b1;
            out_d       = pres.res;
          end
        end
      end
      ST_READ: begin
        if (issue) begin
          rd_addr_d = rd_addr_q + FW'(1);
          rd_idx_d  = rd_addr_q[AW-1:0];
          rd_pend_d = 1'b1;
        end else if (move) begin
          rd_pend_d = 1'b0;
        end
        if (move) begin
          out_valid_d      = 1'b1;
          out_d.host_valid = 1'b1;
          out_d.host_byte  = rd_data;
          out_d.host_last  = rd_last;
          out_d.line_reply = rd_last ? REPLY_ACK : REPLY_NONE;
          out_d.status     = ST_FRAME_OK;
          if (rd_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      rd_addr_q   <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      rd_addr_q   <= rd_addr_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    out_q    <= out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign host_valid_o = out_q.host_valid;
  assign host_byte_o  = out_q.host_byte;
  assign host_last_o  = out_q.host_last;
  assign line_reply_o = out_q.line_reply;
  assign status_o     = out_q.status;

  // pending read data only exists during readout
  a_pend_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> state_q == ST_READ)
    else $error("read data pending outside readout");

  // read address never runs past the frame length
  a_addr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> rd_addr_q <= len_q)
    else $error("read address past frame length");

  // a good frame holds at least start, length and checksum and fits the store
  a_frame_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && pres.frame_ok) |-> (plen >= FW'(3)) && (int'(plen) <= MAX_FRAME))
    else $error("frame length out of range");

  // a line reply is only given on the last result of an input
  a_reply_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.line_reply != REPLY_NONE) |-> out_q.host_last)
    else $error("line reply on a result that is not last");

endmodule

`default_nettype wire

// ===== rtl/sfr_frame_store.sv =====
// frame byte memory, one write port and one registered read port
`default_nettype none

module sfr_frame_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [7:0]    wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic      [7:0]    rd_data_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data valid in the cycle after enable
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/sfr_parser.sv =====
// frame parser: assembly state, checksum, length checks and result decode
`default_nettype none

module sfr_parser import sfr_pkg::*; #(
  parameter int MAX_FRAME = MaxFrameDef,
  parameter int AW        = $clog2(MAX_FRAME),
  parameter int FW        = $clog2(MAX_FRAME + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          fire_i,
  input  wire logic [1:0]    req_type_i,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic [31:0]   now_ms_i,
  input  wire cfg_t          cfg_i,
  output parse_t             parse_o,
  output logic      [FW-1:0] len_o,
  output logic               wr_en_o,
  output logic      [AW-1:0] wr_addr_o,
  output logic      [7:0]    wr_data_o
);

  logic [FW-1:0] fill_q, fill_d;
  logic [FW-1:0] exp_q, exp_d;
  logic [7:0]    chk_q, chk_d;
  logic [31:0]   start_q, start_d;

  logic [31:0]   elapsed;
  logic          in_guard;
  logic          first;
  logic [FW-1:0] fill_new;
  logic [FW-1:0] exp_cur;
  logic [FW-1:0] exp_new;
  logic [7:0]    chk_cur;
  logic [8:0]    total;
  logic          wr_en;

  assign elapsed  = now_ms_i - start_q;
  assign in_guard = elapsed < {16'h0000, cfg_i.guard};
  assign first    = (fill_q == '0);
  assign fill_new = fill_q + FW'(1);
  assign exp_cur  = first ? '0 : exp_q;
  assign chk_cur  = first ? CHECK_SEED : chk_q;
  assign total    = {1'b0, data_byte_i} + 9'd2;

  // decode one input against the assembly state
  always_comb begin
    parse_o            = '0;
    parse_o.res.host_last = 1'b1;
    fill_d             = fill_q;
    exp_d              = exp_q;
    chk_d              = chk_q;
    start_d            = start_q;
    exp_new            = exp_cur;
    wr_en              = 1'b0;
    case (req_type_i)
      REQ_TIMEOUT: begin
        parse_o.res.status = ST_IGNORED;
        if (!in_guard) begin
          exp_d = '0;
          if (!first) begin
            fill_d                 = '0;
            chk_d                  = CHECK_SEED;
            parse_o.res.host_valid = 1'b1;
            parse_o.res.host_byte  = cfg_i.nack;
            parse_o.res.status     = ST_INCOMPLETE;
          end
        end
      end
      REQ_BYTE: begin
        if (first && (data_byte_i == cfg_i.ack || data_byte_i == cfg_i.nack ||
                      data_byte_i == cfg_i.can)) begin
          parse_o.res.host_valid = 1'b1;
          parse_o.res.host_byte  = data_byte_i;
          parse_o.res.status     = ST_CONTROL;
        end else if (first && data_byte_i != cfg_i.sof) begin
          parse_o.res.host_valid = 1'b1;
          parse_o.res.host_byte  = cfg_i.nack;
          parse_o.res.status     = ST_UNKNOWN;
        end else begin
          wr_en = 1'b1;
          if (first) begin
            start_d = now_ms_i;
          end
          // length byte sets the frame size
          if (exp_cur == '0 && fill_new == FW'(2)) begin
            exp_new = total[FW-1:0];
          end
          if (exp_cur == '0 && fill_new == FW'(2) &&
              (data_byte_i == 8'h00 || total > 9'(MAX_FRAME))) begin
            fill_d                 = '0;
            exp_d                  = '0;
            chk_d                  = CHECK_SEED;
            parse_o.res.host_valid = 1'b1;
            parse_o.res.host_byte  = cfg_i.nack;
            parse_o.res.status     = ST_BAD_LEN;
          end else if (exp_new != '0 && fill_new == exp_new) begin
            // checksum byte closes the frame
            fill_d = '0;
            exp_d  = '0;
            chk_d  = CHECK_SEED;
            if (chk_cur != data_byte_i) begin
              parse_o.res.host_valid = 1'b1;
              parse_o.res.host_byte  = cfg_i.nack;
              parse_o.res.line_reply = REPLY_NACK;
              parse_o.res.status     = ST_CHECKSUM;
            end else begin
              parse_o.frame_ok   = 1'b1;
              parse_o.res.status = ST_FRAME_OK;
            end
          end else if (int'(fill_new) >= MAX_FRAME) begin
            // hard bound on the store
            fill_d                 = '0;
            exp_d                  = '0;
            chk_d                  = CHECK_SEED;
            parse_o.res.host_valid = 1'b1;
            parse_o.res.host_byte  = cfg_i.nack;
            parse_o.res.status     = ST_BAD_LEN;
          end else begin
            fill_d             = fill_new;
            exp_d              = exp_new;
            chk_d              = (fill_new >= FW'(2)) ? (chk_cur ^ data_byte_i) : chk_cur;
            parse_o.res.status = ST_STORED;
          end
        end
      end
      default: begin
        fill_d             = '0;
        exp_d              = '0;
        chk_d              = CHECK_SEED;
        parse_o.res.status = ST_LINK_ERR;
      end
    endcase
  end

  // assembly state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      exp_q   <= '0;
      chk_q   <= CHECK_SEED;
      start_q <= '0;
    end else if (fire_i) begin
      fill_q  <= fill_d;
      exp_q   <= exp_d;
      chk_q   <= chk_d;
      start_q <= start_d;
    end
  end

  assign len_o     = fill_new;
  assign wr_en_o   = fire_i && wr_en;
  assign wr_addr_o = fill_q[AW-1:0];
  assign wr_data_o = data_byte_i;

endmodule

`default_nettype wire

// ===== dv/tb_serial_frame_receiver.sv =====
// self-checking testbench for the serial frame receiver
module tb_serial_frame_receiver;
  timeunit 1ns;
  timeprecision 1ps;
  import sfr_pkg::*;

  localparam int MAX_FRAME = MaxFrameDef;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int PH_PRESSURE = 4;
  localparam int SHOW_LIMIT = 10;

  // request types with no name in the package
  localparam logic [1:0] REQ_LINK_ERR = 2'd2;
  localparam logic [1:0] REQ_RESERVED = 2'd3;

  // one link event as presented on the input channel
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [31:0] stamp;
  } link_item_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [1:0]          req_type_i = REQ_BYTE;
  logic [7:0]          data_byte_i = 8'h00;
  logic [31:0]         now_ms_i = 32'd0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                host_valid_o;
  logic [7:0]          host_byte_o;
  logic                host_last_o;
  logic [1:0]          line_reply_o;
  logic [3:0]          status_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = REG_GUARD;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  serial_frame_receiver #(.MAX_FRAME(MAX_FRAME)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .data_byte_i  (data_byte_i),
    .now_ms_i     (now_ms_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .host_valid_o (host_valid_o),
    .host_byte_o  (host_byte_o),
    .host_last_o  (host_last_o),
    .line_reply_o (line_reply_o),
    .status_o     (status_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  link_item_t link_events[$];
  result_t    host_results_due[$];
  int         fail_cnt = 0;
  int         n_queued = 0;
  int         phase_id = 0;
  bit         steady = 1'b0;
  int         cycle_cnt = 0;

  // register copies kept by the parser prediction
  logic [15:0] reg_guard = GUARD_RST;
  logic [7:0]  reg_sof = SOF_RST;
  logic [7:0]  reg_ack = ACK_RST;
  logic [7:0]  reg_nack = NACK_RST;
  logic [7:0]  reg_can = CAN_RST;

  // parser state of the prediction
  logic [7:0]  rx_store[64];
  logic [6:0]  rx_fill = '0;
  logic [6:0]  rx_total = '0;
  logic [7:0]  rx_check = CHECK_SEED;
  logic [31:0] rx_start_ms = '0;

  // stimulus time base
  logic [31:0] gen_ms = 32'd10000;
  logic [31:0] last_sof_ms = 32'd10000;

  function automatic void queue_result(logic valid, logic [7:0] data, logic last,
                                       logic [1:0] reply, logic [3:0] st);
    result_t r;
    r.host_valid = valid;
    r.host_byte  = data;
    r.host_last  = last;
    r.line_reply = reply;
    r.status     = st;
    host_results_due.insert(host_results_due.size(), r);
  endfunction

  function automatic void drop_partial_frame();
    rx_fill  = '0;
    rx_total = '0;
    rx_check = CHECK_SEED;
  endfunction

  // predicted host results for one accepted link event
  function automatic void parse_link_event(link_item_t it);
    logic [31:0] age;
    logic [7:0]  b;
    b = it.data;
    if (it.kind == REQ_TIMEOUT) begin
      age = it.stamp - rx_start_ms;
      if (age < {16'd0, reg_guard}) begin
        queue_result(1'b0, 8'h00, 1'b1, REPLY_NONE, ST_IGNORED);
        return;
      end
      rx_total = '0;
      if (rx_fill != 0) begin
        drop_partial_frame();
        queue_result(1'b1, reg_nack, 1'b1, REPLY_NONE, ST_INCOMPLETE);
      end else begin
        queue_result(1'b0, 8'h00, 1'b1, REPLY_NONE, ST_IGNORED);
      end
      return;
    end
    if (it.kind != REQ_BYTE) begin
      drop_partial_frame();
      queue_result(1'b0, 8'h00, 1'b1, REPLY_NONE, ST_LINK_ERR);
      return;
    end
    // idle: control codes take precedence over the start code
    if (rx_fill == 0) begin
      if (b == reg_ack || b == reg_nack || b == reg_can) begin
        queue_result(1'b1, b, 1'b1, REPLY_NONE, ST_CONTROL);
        return;
      end
      if (b != reg_sof) begin
        queue_result(1'b1, reg_nack, 1'b1, REPLY_NONE, ST_UNKNOWN);
        return;
      end
      rx_start_ms = it.stamp;
      rx_check    = CHECK_SEED;
      rx_total    = '0;
    end
    rx_store[rx_fill[5:0]] = b;
    rx_fill = rx_fill + 7'd1;
    // length byte: zero or oversize rejected
    if (rx_total == 0 && rx_fill == 7'd2) begin
      if (b == 8'd0 || int'(b) + 2 > MAX_FRAME) begin
        drop_partial_frame();
        queue_result(1'b1, reg_nack, 1'b1, REPLY_NONE, ST_BAD_LEN);
        return;
      end
      rx_total = 7'(int'(b) + 2);
    end
    // checksum byte closes the frame
    if (rx_total != 0 && rx_fill == rx_total) begin
      if (rx_check != b) begin
        queue_result(1'b1, reg_nack, 1'b1, REPLY_NACK, ST_CHECKSUM);
      end else begin
        for (int i = 0; i < int'(rx_fill); i++) begin
          queue_result(1'b1, rx_store[i], i + 1 == int'(rx_fill),
                       (i + 1 == int'(rx_fill)) ? REPLY_ACK : REPLY_NONE, ST_FRAME_OK);
        end
      end
      drop_partial_frame();
      return;
    end
    if (rx_fill >= 7'd2) rx_check = rx_check ^ b;
    if (rx_fill >= 7'(MAX_FRAME)) begin
      drop_partial_frame();
      queue_result(1'b1, reg_nack, 1'b1, REPLY_NONE, ST_BAD_LEN);
      return;
    end
    queue_result(1'b0, 8'h00, 1'b1, REPLY_NONE, ST_STORED);
  endfunction

  // input driver: holds a stalled transaction, idles at random otherwise
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      parse_link_event(link_events[0]);
      void'(link_events.pop_front());
    end
    if (!(in_valid_i && in_stall_o)) begin
      if (link_events.size() != 0 && (steady || $urandom_range(99) >= 36)) begin
        in_valid_i  <= 1'b1;
        req_type_i  <= link_events[0].kind;
        data_byte_i <= link_events[0].data;
        now_ms_i    <= link_events[0].stamp;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output stall: random, plus one long hold-off in the pressure phase
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (phase_id == PH_PRESSURE && !hold_done && in_valid_i) begin
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_done   <= 1'b1;
    end else begin
      out_stall_i <= !steady && ($urandom_range(99) < 36);
    end
  end

  function automatic void report_mismatch(string what, result_t want, result_t got);
    fail_cnt++;
    if (fail_cnt <= SHOW_LIMIT) begin
      $display("%0t: %s: want v=%0b byte=%02h last=%0b reply=%0d status=%0d", $time, what,
               want.host_valid, want.host_byte, want.host_last, want.line_reply,
               want.status);
      $display("%0t: %s:  got v=%0b byte=%02h last=%0b reply=%0d status=%0d", $time, what,
               got.host_valid, got.host_byte, got.host_last, got.line_reply, got.status);
    end
  endfunction

  // result monitor
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (out_valid_o && !out_stall_i) begin
      got.host_valid = host_valid_o;
      got.host_byte  = host_byte_o;
      got.host_last  = host_last_o;
      got.line_reply = line_reply_o;
      got.status     = status_o;
      if (host_results_due.size() == 0) begin
        report_mismatch("unexpected result", '0, got);
      end else begin
        want = host_results_due.pop_front();
        if (got.host_valid !== want.host_valid || got.host_byte !== want.host_byte ||
            got.host_last !== want.host_last || got.line_reply !== want.line_reply ||
            got.status !== want.status) begin
          report_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_GUARD: reg_guard = val;
      REG_SOF:   reg_sof = val[7:0];
      REG_ACK:   reg_ack = val[7:0];
      REG_NACK:  reg_nack = val[7:0];
      REG_CAN:   reg_can = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [15:0] guard, input logic [7:0] sof,
                          input logic [7:0] ack, input logic [7:0] nack,
                          input logic [7:0] can);
    write_reg(REG_GUARD, guard);
    write_reg(REG_SOF, {8'h00, sof});
    write_reg(REG_ACK, {8'h00, ack});
    write_reg(REG_NACK, {8'h00, nack});
    write_reg(REG_CAN, {8'h00, can});
  endtask

  // wait until every transaction went through and the block has settled
  task automatic wait_drained();
    do @(negedge clk_i);
    while (link_events.size() != 0 || host_results_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic add_item(input logic [1:0] kind, input logic [7:0] data,
                          input logic [31:0] stamp);
    link_item_t it;
    it.kind  = kind;
    it.data  = data;
    it.stamp = stamp;
    link_events.insert(link_events.size(), it);
    n_queued++;
  endtask

  function automatic logic [31:0] next_ms();
    gen_ms = gen_ms + 32'($urandom_range(40));
    return gen_ms;
  endfunction

  function automatic logic [7:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 4) return 8'(MAX_FRAME - 2);
    if (r < 12) return 8'($urandom_range(11, MAX_FRAME - 3));
    return 8'($urandom_range(1, 10));
  endfunction

  function automatic logic [7:0] pick_control();
    case ($urandom_range(2))
      0: return reg_ack;
      1: return reg_nack;
      default: return reg_can;
    endcase
  endfunction

  function automatic logic [31:0] past_guard();
    gen_ms = last_sof_ms + {16'd0, reg_guard} + 32'($urandom_range(2000));
    return gen_ms;
  endfunction

  // well-formed frame with random payload, checksum optionally damaged
  task automatic add_frame(input logic [7:0] len, input bit damage);
    logic [7:0] sum;
    logic [7:0] v;
    last_sof_ms = next_ms();
    add_item(REQ_BYTE, reg_sof, last_sof_ms);
    add_item(REQ_BYTE, len, next_ms());
    sum = CHECK_SEED ^ len;
    for (int i = 1; i < int'(len); i++) begin
      v = 8'($urandom_range(255));
      sum = sum ^ v;
      add_item(REQ_BYTE, v, next_ms());
    end
    if (damage) sum = sum ^ (8'h01 << $urandom_range(7));
    add_item(REQ_BYTE, sum, next_ms());
  endtask

  // frame cut short, then ended by a timeout or a link error
  task automatic add_broken();
    logic [7:0] len;
    int         sent;
    len  = 8'($urandom_range(2, 20));
    sent = $urandom_range(0, int'(len) - 1);
    last_sof_ms = next_ms();
    add_item(REQ_BYTE, reg_sof, last_sof_ms);
    add_item(REQ_BYTE, len, next_ms());
    for (int i = 0; i < sent; i++) add_item(REQ_BYTE, 8'($urandom_range(255)), next_ms());
    case ($urandom_range(9))
      0, 1, 2, 3, 4: add_item(REQ_TIMEOUT, 8'($urandom_range(255)), past_guard());
      5, 6, 7: add_item(REQ_LINK_ERR, 8'($urandom_range(255)), next_ms());
      default: begin
        if (reg_guard != 0) begin
          add_item(REQ_TIMEOUT, 8'h00,
                   last_sof_ms + 32'($urandom_range(0, int'(reg_guard) - 1)));
        end
        add_item(REQ_RESERVED, 8'($urandom_range(255)), next_ms());
      end
    endcase
  endtask

  task automatic add_timeout();
    logic [31:0] stamp;
    case ($urandom_range(3))
      0: stamp = last_sof_ms + {16'd0, reg_guard} - 32'd1;
      1: stamp = last_sof_ms + {16'd0, reg_guard};
      2: stamp = next_ms();
      default: stamp = $urandom();
    endcase
    add_item(REQ_TIMEOUT, 8'($urandom_range(255)), stamp);
  endtask

  // mostly well-formed frames, the rest noise and broken sequences
  task automatic add_random(input int count);
    int target;
    int pick;
    target = n_queued + count;
    while (n_queued < target) begin
      pick = $urandom_range(99);
      if (pick < 55) add_frame(pick_len(), 1'b0);
      else if (pick < 63) add_frame(pick_len(), 1'b1);
      else if (pick < 71) add_broken();
      else if (pick < 78) add_item(REQ_BYTE, pick_control(), next_ms());
      else if (pick < 83) add_item(REQ_BYTE, 8'($urandom_range(255)), next_ms());
      else if (pick < 89) add_timeout();
      else if (pick < 93) begin
        add_item(($urandom_range(1) != 0) ? REQ_RESERVED : REQ_LINK_ERR,
                 8'($urandom_range(255)), next_ms());
      end else if (pick < 97) begin
        last_sof_ms = next_ms();
        add_item(REQ_BYTE, reg_sof, last_sof_ms);
        add_item(REQ_BYTE, ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(63, 255)),
                 next_ms());
      end else begin
        gen_ms = $urandom();
      end
    end
  endtask

  // test sequence
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // control bytes and an unknown start byte while idle
    add_item(REQ_BYTE, ACK_RST, 32'd10);
    add_item(REQ_BYTE, NACK_RST, 32'd20);
    add_item(REQ_BYTE, CAN_RST, 32'd30);
    add_item(REQ_BYTE, 8'hFF, 32'd40);
    // timeouts before any start byte, guard counted from time zero
    add_item(REQ_TIMEOUT, 8'h00, 32'd0);
    add_item(REQ_TIMEOUT, 8'hFF, 32'd1500);
    // one-byte frame across the ms counter wrap, timeout inside the guard
    add_item(REQ_BYTE, SOF_RST, 32'hFFFF_FFF0);
    add_item(REQ_BYTE, 8'd1, 32'hFFFF_FFF8);
    add_item(REQ_TIMEOUT, 8'h00, 32'h0000_0100);
    add_item(REQ_BYTE, CHECK_SEED ^ 8'd1, 32'h0000_0200);
    // zero length and oversize length
    add_item(REQ_BYTE, SOF_RST, 32'd5000);
    add_item(REQ_BYTE, 8'd0, 32'd5001);
    add_item(REQ_BYTE, SOF_RST, 32'd5002);
    add_item(REQ_BYTE, 8'd63, 32'd5003);
    // damaged checksum
    add_item(REQ_BYTE, SOF_RST, 32'd5100);
    add_item(REQ_BYTE, 8'd2, 32'd5101);
    add_item(REQ_BYTE, 8'hA5, 32'd5102);
    add_item(REQ_BYTE, CHECK_SEED ^ 8'd2 ^ 8'hA5 ^ 8'h80, 32'd5103);
    // timeout one ms inside the guard, then exactly at it
    add_item(REQ_BYTE, SOF_RST, 32'd6000);
    add_item(REQ_BYTE, 8'd3, 32'd6001);
    add_item(REQ_TIMEOUT, 8'h00, 32'd7499);
    add_item(REQ_TIMEOUT, 8'h00, 32'd7500);
    // link error mid frame, then the reserved request type
    add_item(REQ_BYTE, SOF_RST, 32'd8000);
    add_item(REQ_LINK_ERR, 8'h00, 32'd8001);
    add_item(REQ_RESERVED, 8'hFF, 32'hFFFF_FFFF);
    wait_drained();

    // codes that coincide: start equals ack, nack equals cancel
    set_regs(16'd0, 8'h33, 8'h33, 8'h55, 8'h55);
    add_item(REQ_BYTE, 8'h33, 32'd9000);
    add_item(REQ_BYTE, 8'h55, 32'd9001);
    add_item(REQ_TIMEOUT, 8'h00, 32'd9002);
    wait_drained();

    // zero guard, extreme codes, no idling on either side
    set_regs(16'd0, 8'hFF, 8'h00, 8'h80, 8'h7F);
    steady = 1'b1;
    add_random(75);
    wait_drained();
    steady = 1'b0;

    // widest guard, long receiver hold-off
    set_regs(16'hFFFF, 8'h00, 8'hFE, 8'h01, 8'h02);
    phase_id = PH_PRESSURE;
    add_random(80);
    wait_drained();
    phase_id = 0;

    // random register values
    set_regs(16'($urandom_range(3000)), 8'($urandom_range(255)), 8'($urandom_range(255)),
             8'($urandom_range(255)), 8'($urandom_range(255)));
    add_random(75);
    wait_drained();

    // back to the reset values
    set_regs(GUARD_RST, SOF_RST, ACK_RST, NACK_RST, CAN_RST);
    add_random(70);
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== serial_frame_receiver.f =====
rtl/sfr_pkg.sv
rtl/sfr_frame_store.sv
rtl/sfr_parser.sv
rtl/serial_frame_receiver.sv
dv/tb_serial_frame_receiver.sv
